/* rtl/fbc128_pkg.sv */
// Package for the 128-bit Feistel block cipher: codes, constants and the
// byte and nibble transforms used by both the round pipeline and the key schedule.
// No dependencies.
`timescale 1ns / 1ps

package fbc128_pkg;

  localparam int ROUNDS_DEF = 8;
  localparam int WORD_W     = 64;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_t;

  localparam logic [3:0] NIB_BOX [16] = '{
    4'h4, 4'hc, 4'h0, 4'h8, 4'h6, 4'he, 4'h1, 4'hb,
    4'h9, 4'hd, 4'h2, 4'h5, 4'ha, 4'hf, 4'h3, 4'h7
  };

  localparam logic [63:0] PERM_KEEP = 64'h0000FF00FF000000;
  localparam logic [63:0] PERM_SWAP = 64'h00FF00FF00FF00FF;
  localparam logic [63:0] PERM_LOW  = 64'h000000000000FF00;
  localparam logic [63:0] PERM_HIGH = 64'hFF00000000000000;
  localparam logic [7:0]  AFF_ADD   = 8'h9B;
  localparam logic [7:0]  AFF_MUL   = 8'd3;
  localparam logic [7:0]  AFF_INV   = 8'hAB;
  localparam logic [4:0]  RX_HI_OFS = 5'd13;
  localparam logic [4:0]  RX_LO_OFS = 5'd29;

  function automatic logic [63:0] sub_nibbles(input logic [63:0] x);
    logic [63:0] y;
    y = '0;
    for (int n = 0; n < 16; n++) begin
      y[4*n +: 4] = NIB_BOX[x[4*n +: 4]];
    end
    return y;
  endfunction

  // Byte k is rotated left by 7 - k.
  function automatic logic [63:0] rot_bytes(input logic [63:0] x);
    logic [63:0] y;
    logic [15:0] w;
    y = '0;
    for (int k = 0; k < 8; k++) begin
      w = {x[8*k +: 8], x[8*k +: 8]} << (7 - k);
      y[8*k +: 8] = w[15:8];
    end
    return y;
  endfunction

  function automatic logic [63:0] perm_bytes(input logic [63:0] x);
    return (x & PERM_KEEP)
         ^ ({x[31:0], x[63:32]} & PERM_SWAP)
         ^ ((x >> 48) & PERM_LOW)
         ^ ((x << 48) & PERM_HIGH);
  endfunction

  function automatic logic [63:0] affine_fwd(input logic [63:0] x);
    logic [63:0] y;
    logic [7:0]  b;
    y = '0;
    for (int k = 0; k < 8; k++) begin
      b = x[8*k +: 8];
      y[8*k +: 8] = 8'(b * AFF_MUL) + AFF_ADD;
    end
    return y;
  endfunction

  function automatic logic [63:0] affine_inv(input logic [63:0] x);
    logic [63:0] y;
    logic [7:0]  d;
    y = '0;
    for (int k = 0; k < 8; k++) begin
      d = x[8*k +: 8] - AFF_ADD;
      y[8*k +: 8] = 8'(d * AFF_INV);
    end
    return y;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

  // A rotation by zero returns the word itself, so that half xors to zero.
  function automatic logic [63:0] rot_xor(input logic [63:0] x, input logic [4:0] i);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = x[63:32] ^ rotl32(x[63:32], i + RX_HI_OFS);
    lo = x[31:0]  ^ rotl32(x[31:0],  i + RX_LO_OFS);
    return {hi, lo};
  endfunction

  function automatic logic [63:0] round_fn(input logic [63:0] x, input logic [63:0] k);
    return rot_bytes(sub_nibbles(x ^ k));
  endfunction

endpackage

/* rtl/feistel_block_cipher_128_unit.sv */
// Top level of the 128-bit Feistel block cipher: key registers, iterative key
// schedule, round key store and a pipeline of one register stage per round.
// Depends on fbc128_pkg.
// Each request passes an input register stage and then one register stage per round before the out_valid strobe.
// Throughput: one request per cycle while busy is low; results cannot be stalled.
// The key schedule runs after reset and after every key write, one round key per
// cycle; busy is high while it runs.
// Reset (synchronous, rst_n low) clears the key to zero, empties the pipeline
// and starts a key schedule run.
`timescale 1ns / 1ps

module feistel_block_cipher_128_unit
  import fbc128_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [WORD_W-1:0]    in_data_high,
  input  logic [WORD_W-1:0]    in_data_low,
  output logic                 out_valid,
  output logic [WORD_W-1:0]    out_result_high,
  output logic [WORD_W-1:0]    out_result_low,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam int CW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // Key registers and key schedule.
  logic [WORD_W-1:0] key_high_r, key_high_nxt;
  logic [WORD_W-1:0] key_low_r, key_low_nxt;
  logic              key_load;
  logic [WORD_W-1:0] ks_h_r, ks_l_r;
  logic [WORD_W-1:0] ks_l_nxt;
  logic [CW-1:0]     ks_cnt_r;
  logic              ks_run_r;
  logic              ks_last;
  logic [WORD_W-1:0] rk_r [ROUNDS];

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    key_load     = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_HIGH: begin
          key_high_nxt = cfg_wdata;
          key_load     = 1'b1;
        end
        CFG_KEY_LOW: begin
          key_low_nxt = cfg_wdata;
          key_load    = 1'b1;
        end
        default: key_load = 1'b0;
      endcase
    end
  end

  assign ks_l_nxt = affine_fwd(ks_h_r ^ perm_bytes(rot_xor(sub_nibbles(ks_l_r), 5'(ks_cnt_r))));
  assign ks_last  = (ks_cnt_r == CW'(ROUNDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      ks_h_r     <= '0;
      ks_l_r     <= '0;
      ks_cnt_r   <= '0;
      ks_run_r   <= 1'b1;
    end else if (key_load) begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      ks_h_r     <= key_high_nxt;
      ks_l_r     <= key_low_nxt;
      ks_cnt_r   <= '0;
      ks_run_r   <= 1'b1;
    end else if (ks_run_r) begin
      ks_h_r   <= ks_l_r;
      ks_l_r   <= ks_l_nxt;
      ks_cnt_r <= ks_last ? '0 : ks_cnt_r + CW'(1);
      ks_run_r <= !ks_last;
    end
  end

  // Round key i is the low half of the chain before step i.
  always_ff @(posedge clk) begin
    if (ks_run_r) begin
      rk_r[ks_cnt_r] <= ks_l_r;
    end
  end

  assign busy = ks_run_r;

  // Round pipeline: stage 0 holds the request, stage j+1 holds it after round j.
  logic              vld_r [ROUNDS+1];
  logic              fn_r  [ROUNDS+1];
  logic [WORD_W-1:0] hi_r  [ROUNDS+1];
  logic [WORD_W-1:0] lo_r  [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    fn_r[0] <= in_func;
    hi_r[0] <= in_data_high;
    lo_r[0] <= in_data_low;
  end

  for (genvar j = 0; j < ROUNDS; j++) begin : g_round
    logic [WORD_W-1:0] enc_t, dec_t;
    logic [WORD_W-1:0] hi_nxt, lo_nxt;

    always_comb begin
      enc_t = affine_fwd(perm_bytes(hi_r[j]) ^ round_fn(lo_r[j], rk_r[j]));
      dec_t = affine_inv(lo_r[j]) ^ round_fn(hi_r[j], rk_r[ROUNDS-1-j]);
      if (fn_r[j] == FUNC_DEC) begin
        hi_nxt = perm_bytes(dec_t);
        lo_nxt = hi_r[j];
      end else begin
        hi_nxt = lo_r[j];
        lo_nxt = enc_t;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      fn_r[j+1] <= fn_r[j];
      hi_r[j+1] <= hi_nxt;
      lo_r[j+1] <= lo_nxt;
    end
  end

  assign out_valid       = vld_r[ROUNDS];
  assign out_result_high = hi_r[ROUNDS];
  assign out_result_low  = lo_r[ROUNDS];

  // Every accepted request comes out after the full pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(ROUNDS+1) out_valid)
    else $error("request did not reach the output after the pipeline depth");

  // A key write always starts a key schedule run.
  a_key_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("key write did not start the key schedule");

  // The schedule counter never leaves the round key store.
  a_ks_count: assert property (@(posedge clk) disable iff (!rst_n)
    ks_run_r |-> (ks_cnt_r <= CW'(ROUNDS - 1)))
    else $error("key schedule counter out of range");

  // The schedule stops right after writing the last round key.
  a_ks_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (ks_run_r && ks_last && !cfg_we) |=> !busy)
    else $error("key schedule did not finish after the last round key");

endmodule
